/* src/tss_pkg.sv */
package tss_pkg;

   localparam int SLOT_W   = 4;
   localparam int CREDIT_W = 9;
   localparam int PRIO_W   = 8;
   localparam int COUNT_W  = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
   localparam logic [PRIO_W-1:0]  PRIO_RESET = 8'd15;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_CANCEL = 2'd1,
      OP_SCHED  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_MAIN    = 3'd2,
      ST_INVALID = 3'd3,
      ST_WARN    = 3'd4,
      ST_NONE    = 3'd5,
      ST_STUCK   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_SCAN_LAST,
      ENG_REFRESH,
      ENG_REFRESH_LAST,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic                rd_en;
      logic [SLOT_W-1:0]   rd_addr;
      logic                wr_en;
      logic [SLOT_W-1:0]   wr_addr;
      logic [CREDIT_W-1:0] wr_data;
   } credit_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] pick;
      logic              stuck;
   } eng_result_type;

endpackage

/* src/thread_slot_scheduler_unit.sv */
// Thread slot scheduler: keeps NUM_SLOTS thread slots, slot 0 being the main
// thread, and answers every request transfer with exactly one response
// transfer. Allocate and cancel work on the slot flags and the thread count
// and answer as soon as the output register can take the response. With
// threads live, schedule walks the run credits, which sit in a memory with
// one read and one write port, from the top slot down to slot 1 at one slot
// per cycle: one walk when a running slot has credit left; when all credits
// are spent, a refresh pass and then a second walk, or a stuck status if the
// priority is zero. One request is in flight at a time; the next one is taken
// as soon as the current response sits in the output register. The priority
// register may be written only while no request is outstanding.
module thread_slot_scheduler_unit
   import tss_pkg::*;
#(
   parameter int NUM_SLOTS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [SLOT_W-1:0] req_tid,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [2:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [PRIO_W-1:0] csr_priority_cfg
);

   localparam int IDX_W = $clog2(NUM_SLOTS);

   logic                 busy_ff, busy_in;
   op_type               op_ff, op_in;
   logic [SLOT_W-1:0]    tid_ff, tid_in;
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PRIO_W-1:0]    prio_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 req_fire;
   logic                 can_load;
   logic                 eng_start;
   logic                 eng_take;
   logic                 free_found;
   logic [SLOT_W-1:0]    free_slot;
   credit_req_type       mem_req;
   logic [CREDIT_W-1:0]  rd_data;
   eng_result_type       eng_result;

   assign req_ready  = !busy_ff;
   assign req_fire   = req_valid && req_ready;
   assign can_load   = !rsp_valid_ff || rsp_ready;
   assign eng_start  = req_fire && (op_type'(req_op) == OP_SCHED) && (count_ff != '0);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      op_in         = op_ff;
      tid_in        = tid_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      eng_take      = 1'b0;

      if (req_fire) begin
         busy_in = 1'b1;
         op_in   = op_type'(req_op);
         tid_in  = req_tid;
      end else if (busy_ff && can_load) begin
         case (op_ff)
            OP_ALLOC: begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
               if (free_found) begin
                  used_in[free_slot[IDX_W-1:0]] = 1'b1;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
                  rsp_slot_in   = free_slot;
                  rsp_status_in = ST_OK;
               end else begin
                  rsp_slot_in   = '0;
                  rsp_status_in = ST_FULL;
               end
            end
            OP_CANCEL: begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = tid_ff;
               if (tid_ff == '0) begin
                  rsp_status_in = ST_MAIN;
               end else if ({1'b0, tid_ff} >= (SLOT_W + 1)'(NUM_SLOTS)) begin
                  rsp_status_in = ST_INVALID;
               end else begin
                  if (!used_ff[tid_ff[IDX_W-1:0]] || count_ff == '0) begin
                     rsp_status_in = ST_WARN;
                  end else begin
                     rsp_status_in = ST_OK;
                  end
                  used_in[tid_ff[IDX_W-1:0]] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            OP_SCHED: begin
               if (count_ff == '0) begin
                  busy_in       = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_status_in = ST_NONE;
               end else if (eng_result.done) begin
                  eng_take      = 1'b1;
                  busy_in       = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = eng_result.pick;
                  rsp_status_in = eng_result.stuck ? ST_STUCK : ST_OK;
               end
            end
            default: begin
               busy_in       = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         used_ff      <= NUM_SLOTS'(1);
         count_ff     <= '0;
         prio_ff      <= PRIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            prio_ff <= csr_priority_cfg;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tid_ff        <= tid_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   tss_sched_engine #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (eng_start),
      .take    (eng_take),
      .prio    (prio_ff),
      .used    (used_ff),
      .mem_req (mem_req),
      .rd_data (rd_data),
      .result  (eng_result)
   );

   tss_credit_store #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_credit (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

/* src/tss_credit_store.sv */
module tss_credit_store
   import tss_pkg::*;
#(
   parameter int NUM_SLOTS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  credit_req_type      mem_req,
   output logic [CREDIT_W-1:0] rd_data
);

   localparam int IDX_W = $clog2(NUM_SLOTS);

   logic [CREDIT_W-1:0]  mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] written_ff;
   logic [NUM_SLOTS-1:0] written_in;
   logic [CREDIT_W-1:0]  rd_data_ff;
   logic                 rd_valid_ff;

   always_comb begin
      written_in = written_ff;
      if (mem_req.wr_en) begin
         written_in[mem_req.wr_addr[IDX_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff  <= mem[mem_req.rd_addr[IDX_W-1:0]];
         rd_valid_ff <= written_ff[mem_req.rd_addr[IDX_W-1:0]];
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* src/tss_sched_engine.sv */
module tss_sched_engine
   import tss_pkg::*;
#(
   parameter int NUM_SLOTS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 take,
   input  logic [PRIO_W-1:0]    prio,
   input  logic [NUM_SLOTS-1:0] used,
   output credit_req_type       mem_req,
   input  logic [CREDIT_W-1:0]  rd_data,
   output eng_result_type       result
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [SLOT_W-1:0] FIRST_SCAN = SLOT_W'(1);

   eng_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic                rvld_ff, rvld_in;
   logic [SLOT_W-1:0]   raddr_ff, raddr_in;
   logic [CREDIT_W-1:0] best_ff, best_in, best_nx;
   logic                found_ff, found_in, found_nx;
   logic [SLOT_W-1:0]   pick_ff, pick_in, pick_nx;
   logic                stuck_ff, stuck_in;
   logic                hit;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rvld_in  = 1'b0;
      raddr_in = raddr_ff;
      stuck_in = stuck_ff;
      mem_req  = '0;

      hit = rvld_ff && used[raddr_ff[IDX_W-1:0]];

      // running maximum, ties keep the earlier (higher) slot
      best_nx  = best_ff;
      found_nx = found_ff;
      pick_nx  = pick_ff;
      if ((state_ff == ENG_SCAN || state_ff == ENG_SCAN_LAST) && hit &&
          (!found_ff || rd_data > best_ff)) begin
         best_nx  = rd_data;
         found_nx = 1'b1;
         pick_nx  = raddr_ff;
      end
      best_in  = best_nx;
      found_in = found_nx;
      pick_in  = pick_nx;

      // refresh write-back, in the cycle after its read
      if (state_ff == ENG_REFRESH || state_ff == ENG_REFRESH_LAST) begin
         mem_req.wr_en   = hit;
         mem_req.wr_addr = raddr_ff;
         mem_req.wr_data = CREDIT_W'(prio) + {1'b0, rd_data[CREDIT_W-1:1]};
      end

      unique case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               state_in = ENG_SCAN;
               idx_in   = LAST_SLOT;
               best_in  = '0;
               found_in = 1'b0;
               pick_in  = '0;
               stuck_in = 1'b0;
            end
         end
         ENG_SCAN: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff;
            rvld_in         = 1'b1;
            raddr_in        = idx_ff;
            if (idx_ff == FIRST_SCAN) begin
               state_in = ENG_SCAN_LAST;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ENG_SCAN_LAST: begin
            if (found_nx && best_nx == '0) begin
               state_in = ENG_REFRESH;
               idx_in   = '0;
            end else begin
               state_in = ENG_DONE;
            end
         end
         ENG_REFRESH: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff;
            rvld_in         = 1'b1;
            raddr_in        = idx_ff;
            if (idx_ff == LAST_SLOT) begin
               state_in = ENG_REFRESH_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ENG_REFRESH_LAST: begin
            if (prio == '0) begin
               state_in = ENG_DONE;
               stuck_in = 1'b1;
               pick_in  = '0;
            end else begin
               state_in = ENG_SCAN;
               idx_in   = LAST_SLOT;
               best_in  = '0;
               found_in = 1'b0;
               pick_in  = '0;
            end
         end
         ENG_DONE: begin
            if (take) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase

      result.done  = (state_ff == ENG_DONE);
      result.pick  = pick_ff;
      result.stuck = stuck_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rvld_ff  <= rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      raddr_ff <= raddr_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      pick_ff  <= pick_in;
      stuck_ff <= stuck_in;
   end

endmodule

/* tb/sv/tb_thread_slot_scheduler_unit.sv */
module tb_thread_slot_scheduler_unit;
   import tss_pkg::*;

   localparam int NUM_SLOTS   = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 272;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } slot_result_type;

   typedef struct packed {
      bit                is_cfg;
      op_type            op;
      logic [SLOT_W-1:0] tid;
      logic [PRIO_W-1:0] prio;
      bit                typed;
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } script_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_op = OP_NOP;
   logic [SLOT_W-1:0] req_tid = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   logic [SLOT_W-1:0] rsp_slot;
   logic [2:0]        rsp_status;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [PRIO_W-1:0] csr_priority_cfg = '0;

   // shadow of the slot table
   bit   [NUM_SLOTS-1:0] slot_busy = NUM_SLOTS'(1);
   logic [CREDIT_W-1:0]  slot_credit [NUM_SLOTS] = '{default: '0};
   logic [COUNT_W-1:0]   live_threads = '0;
   logic [PRIO_W-1:0]    quantum = PRIO_RESET;

   slot_result_type expected_results [$];
   slot_result_type head_result;
   int              mismatches = 0;
   int              cycle_count = 0;
   bit              no_idle = 1'b0;

   script_row_type script [25] = '{
      '{1, OP_NOP,    4'd0,  8'd0,   0, 4'd0,  ST_OK},
      '{0, OP_SCHED,  4'd0,  8'd0,   1, 4'd0,  ST_NONE},
      '{0, OP_CANCEL, 4'd0,  8'd0,   1, 4'd0,  ST_MAIN},
      '{0, OP_CANCEL, 4'd15, 8'd0,   1, 4'd15, ST_INVALID},
      '{0, OP_CANCEL, 4'd10, 8'd0,   1, 4'd10, ST_INVALID},
      '{0, OP_CANCEL, 4'd9,  8'd0,   1, 4'd9,  ST_WARN},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd1,  ST_OK},
      '{0, OP_SCHED,  4'd0,  8'd0,   1, 4'd0,  ST_STUCK},
      '{1, OP_NOP,    4'd0,  8'd255, 0, 4'd0,  ST_OK},
      '{0, OP_SCHED,  4'd0,  8'd0,   1, 4'd1,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd2,  ST_OK},
      '{0, OP_SCHED,  4'd0,  8'd0,   0, 4'd0,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd3,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd4,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd5,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd6,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd7,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd8,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd9,  ST_OK},
      '{0, OP_ALLOC,  4'd0,  8'd0,   1, 4'd0,  ST_FULL},
      '{0, OP_CANCEL, 4'd1,  8'd0,   1, 4'd1,  ST_OK},
      '{0, OP_SCHED,  4'd0,  8'd0,   0, 4'd0,  ST_OK},
      '{0, OP_CANCEL, 4'd1,  8'd0,   1, 4'd1,  ST_WARN},
      '{0, OP_NOP,    4'd15, 8'd0,   1, 4'd0,  ST_OK},
      '{1, OP_NOP,    4'd0,  8'd15,  0, 4'd0,  ST_OK}
   };

   thread_slot_scheduler_unit #(
      .NUM_SLOTS(NUM_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_tid(req_tid),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_slot(rsp_slot),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_priority_cfg(csr_priority_cfg)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [SLOT_W-1:0] richest_slot(output int best);
      logic [SLOT_W-1:0] pick;
      best = -1;
      pick = '0;
      for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
         if (slot_busy[i] && int'(slot_credit[i]) > best) begin
            best = int'(slot_credit[i]);
            pick = SLOT_W'(i);
         end
      end
      return pick;
   endfunction

   function automatic slot_result_type apply_slot_op(op_type op, logic [SLOT_W-1:0] tid);
      slot_result_type r;
      int           best;
      bit           found;
      logic [SLOT_W-1:0] pick;
      r.slot = '0;
      r.status = ST_OK;
      found = 1'b0;
      case (op)
         OP_ALLOC: begin
            r.status = ST_FULL;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!found && !slot_busy[i]) begin
                  found = 1'b1;
                  slot_busy[i] = 1'b1;
                  if (live_threads < COUNT_MAX)
                     live_threads++;
                  r.slot = SLOT_W'(i);
                  r.status = ST_OK;
               end
            end
         end
         OP_CANCEL: begin
            r.slot = tid;
            if (tid == 0) begin
               r.status = ST_MAIN;
            end else if (int'(tid) >= NUM_SLOTS) begin
               r.status = ST_INVALID;
            end else begin
               if (!slot_busy[tid] || live_threads == 0)
                  r.status = ST_WARN;
               slot_busy[tid] = 1'b0;
               if (live_threads > 0)
                  live_threads--;
            end
         end
         OP_SCHED: begin
            if (live_threads == 0) begin
               r.status = ST_NONE;
            end else begin
               pick = richest_slot(best);
               if (best == 0) begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (slot_busy[i])
                        slot_credit[i] = CREDIT_W'(quantum) + (slot_credit[i] >> 1);
                  end
                  if (quantum == 0) begin
                     pick = '0;
                     r.status = ST_STUCK;
                  end else begin
                     pick = richest_slot(best);
                  end
               end
               r.slot = pick;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_request(input op_type op, input logic [SLOT_W-1:0] tid,
                               input bit typed, input slot_result_type typed_result);
      slot_result_type predicted;
      while (!no_idle && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_tid <= tid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_slot_op(op, tid);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [PRIO_W-1:0] value);
      wait_all_results();
      csr_valid <= 1'b1;
      csr_priority_cfg <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      quantum = value;
   endtask

   // response side: compare against the oldest expectation, random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: slot %0d status %0d", rsp_slot, rsp_status);
            end else begin
               head_result = expected_results.pop_front();
               if (rsp_slot !== head_result.slot || rsp_status !== head_result.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                              head_result.slot, head_result.status, rsp_slot, rsp_status);
               end
            end
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [PRIO_W-1:0] phase_quantum [6];
      op_type            op;
      logic [SLOT_W-1:0] tid;
      int                pick;
      phase_quantum = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd128, 8'd0};
      phase_quantum[3] = PRIO_W'($urandom_range(255));
      phase_quantum[5] = PRIO_W'($urandom_range(2, 40));
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg)
            write_quantum(script[i].prio);
         else
            send_request(script[i].op, script[i].tid, script[i].typed,
                         '{slot: script[i].slot, status: script[i].status});
      end

      for (int phase = 0; phase < 6; phase++) begin
         write_quantum(phase_quantum[phase]);
         no_idle = (phase == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            tid = SLOT_W'($urandom_range(15));
            if (pick < 30) begin
               op = OP_ALLOC;
            end else if (pick < 60) begin
               op = OP_CANCEL;
               pick = $urandom_range(99);
               if (pick < 80)
                  tid = SLOT_W'($urandom_range(NUM_SLOTS - 1, 1));
               else if (pick < 87)
                  tid = '0;
               else
                  tid = SLOT_W'($urandom_range(15, NUM_SLOTS));
            end else if (pick < 95) begin
               op = OP_SCHED;
            end else begin
               op = OP_NOP;
            end
            send_request(op, tid, 1'b0, '0);
            if ($urandom_range(99) == 0)
               wait_all_results();
         end
      end
      no_idle = 1'b0;

      wait_all_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
src/tss_pkg.sv
src/tss_credit_store.sv
src/tss_sched_engine.sv
src/thread_slot_scheduler_unit.sv
tb/sv/tb_thread_slot_scheduler_unit.sv
